/* hdl/pbme_pkg.sv */
package pbme_pkg;

    typedef struct packed {
        logic        opcode;
        logic [27:0] time_ms;
        logic [23:0] freq_q8;
        logic [10:0] level_q10;
    } pbme_in_t;

    typedef struct packed {
        logic [7:0] midi_byte;
        logic       last_byte;
    } pbme_out_t;

    localparam logic OP_BREAK = 1'b0;
    localparam logic OP_END   = 1'b1;

    localparam logic [7:0] NOTE_ON    = 8'h90;
    localparam logic [7:0] NOTE_OFF   = 8'h80;
    localparam logic [7:0] META_BYTE  = 8'hFF;
    localparam logic [7:0] EOT_BYTE   = 8'h2F;
    localparam int         MAX_BYTES  = 14;

    // one encoded event: up to 4 delta bytes plus 3 bytes
    typedef struct packed {
        logic [2:0]       nbytes;
        logic [6:0][7:0]  bytes;
    } pbme_evt_t;

    // up to 14 bytes per item
    typedef struct packed {
        logic [3:0]        count;
        logic [13:0][7:0]  bytes;
    } pbme_burst_t;

    // 2^((2s-1)/24) scaled by 1e9
    function automatic logic [31:0] thr_rom(input logic [3:0] s);
        logic [31:0] r;
        begin
            unique case (s)
                4'd0:  r = 32'd971531941;
                4'd1:  r = 32'd1029302237;
                4'd2:  r = 32'd1090507733;
                4'd3:  r = 32'd1155352697;
                4'd4:  r = 32'd1224053543;
                4'd5:  r = 32'd1296839555;
                4'd6:  r = 32'd1373953647;
                4'd7:  r = 32'd1455653183;
                4'd8:  r = 32'd1542210825;
                4'd9:  r = 32'd1633915453;
                4'd10: r = 32'd1731073122;
                4'd11: r = 32'd1834008086;
                default: r = 32'd0;
            endcase
            return r;
        end
    endfunction

    // velocity = round(level*127/1024), saturated
    function automatic logic [6:0] velocity_of(input logic [10:0] lvl);
        logic [18:0] p;
        logic [8:0]  v;
        begin
            p = {8'd0, lvl} * 19'd127 + 19'd512;
            v = p[18:10];
            return (v > 9'd127) ? 7'd127 : v[6:0];
        end
    endfunction

    // variable-length delta followed by status, key, velocity
    function automatic pbme_evt_t make_event(input logic [27:0] d, input logic [7:0] st,
                                             input logic [6:0] key, input logic [6:0] vel);
        pbme_evt_t e;
        logic [2:0] g;
        begin
            e = '0;
            if (d[27:21] != 7'd0)
                g = 3'd4;
            else if (d[20:14] != 7'd0)
                g = 3'd3;
            else if (d[13:7] != 7'd0)
                g = 3'd2;
            else
                g = 3'd1;
            e.nbytes = g + 3'd3;
            unique case (g)
                3'd4: begin
                    e.bytes[0] = {1'b1, d[27:21]};
                    e.bytes[1] = {1'b1, d[20:14]};
                    e.bytes[2] = {1'b1, d[13:7]};
                    e.bytes[3] = {1'b0, d[6:0]};
                end
                3'd3: begin
                    e.bytes[0] = {1'b1, d[20:14]};
                    e.bytes[1] = {1'b1, d[13:7]};
                    e.bytes[2] = {1'b0, d[6:0]};
                end
                3'd2: begin
                    e.bytes[0] = {1'b1, d[13:7]};
                    e.bytes[1] = {1'b0, d[6:0]};
                end
                default: e.bytes[0] = {1'b0, d[6:0]};
            endcase
            e.bytes[g]        = st;
            e.bytes[g + 3'd1] = {1'b0, key};
            e.bytes[g + 3'd2] = {1'b0, vel};
            return e;
        end
    endfunction

endpackage

/* hdl/pitch_breakpoint_to_midi_events.sv */
// the first byte is offered once the request has passed the staging register and been loaded into the burst register
// throughput: one output byte per cycle while out_ready is high, an item emits 0 to 14 bytes
// a new request is taken while the previous burst drains its final byte
// the key is a 127-way threshold compare against a constant table
// reset (rst_n low, asynchronous) clears all note state and the staccato register
module pitch_breakpoint_to_midi_events
    import pbme_pkg::*;
#(
    parameter int TIME_BITS      = 28,
    parameter int FREQ_FRAC_BITS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  pbme_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output pbme_out_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam logic [27:0] TIME_MAX = 28'((64'd1 << TIME_BITS) - 64'd1);

    logic [15:0]  staccato_reg;
    logic         stage_reg;
    pbme_in_t     item_reg;
    logic [27:0]  last_event_reg;
    logic         expect_start_reg;
    logic [6:0]   held_vel_reg;
    logic [6:0]   held_key_reg;
    logic         pending_reg;
    logic [27:0]  pending_start_reg;

    logic         busy;
    logic         take;
    logic         load;
    logic [6:0]   key;
    logic [27:0]  t_sat;
    pbme_burst_t  burst;

    assign cfg_ready = 1'b1;
    assign load      = stage_reg && !busy;
    assign in_ready  = !stage_reg || load;
    assign take      = in_valid && in_ready;

    pbme_key #(.FREQ_FRAC_BITS(FREQ_FRAC_BITS)) u_key (
        .clk  (clk),
        .en   (take),
        .freq (in_data.freq_q8),
        .key  (key)
    );

    pbme_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .burst     (burst),
        .busy      (busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign t_sat = (item_reg.time_ms > TIME_MAX) ? TIME_MAX : item_reg.time_ms;

    // event building and next state for the staged item
    logic [27:0] last_next;
    logic        expect_next;
    logic [6:0]  hvel_next;
    logic [6:0]  hkey_next;
    logic        pend_next;
    logic [27:0] pstart_next;

    always_comb
    begin
        pbme_evt_t   e1;
        pbme_evt_t   e2;
        logic [27:0] gap;
        logic [27:0] d;
        logic [28:0] fin;
        logic [27:0] base;
        logic [6:0]  vel;
        logic [27:0] dl;
        burst       = '0;
        last_next   = last_event_reg;
        expect_next = expect_start_reg;
        hvel_next   = held_vel_reg;
        hkey_next   = held_key_reg;
        pend_next   = pending_reg;
        pstart_next = pending_start_reg;
        dl          = '0;
        vel = velocity_of(item_reg.level_q10);
        gap = (t_sat >= pending_start_reg) ? t_sat - pending_start_reg : '0;
        d   = 28'(({1'b0, gap} + 29'd1) >> 1);
        if (d > {12'd0, staccato_reg})
            d = {12'd0, staccato_reg};
        fin  = {1'b0, pending_start_reg} + {1'b0, d};
        base = pending_reg ? ((fin > {1'b0, TIME_MAX}) ? TIME_MAX : fin[27:0])
                           : last_event_reg;
        e1 = '0;
        e2 = '0;
        if (item_reg.opcode == OP_END)
        begin
            if (pending_reg)
                e1 = make_event({12'd0, staccato_reg}, NOTE_OFF, held_key_reg, held_vel_reg);
            e2.nbytes   = 3'd4;
            e2.bytes[0] = 8'h00;
            e2.bytes[1] = META_BYTE;
            e2.bytes[2] = EOT_BYTE;
            e2.bytes[3] = 8'h00;
            last_next = '0; expect_next = 1'b1; hvel_next = '0; hkey_next = '0;
            pend_next = 1'b0; pstart_next = '0;
        end
        else if (expect_start_reg)
        begin
            if (pending_reg)
                e1 = make_event(d, NOTE_OFF, held_key_reg, held_vel_reg);
            dl = (t_sat >= base) ? t_sat - base : '0;
            e2 = make_event(dl, NOTE_ON, key, vel);
            last_next = t_sat; hkey_next = key; hvel_next = vel;
            pend_next = 1'b0;
            if (staccato_reg != 16'd0)
            begin
                pend_next = 1'b1;
                pstart_next = t_sat;
            end
            expect_next = 1'b0;
        end
        else
        begin
            if (staccato_reg == 16'd0 && !pending_reg)
            begin
                dl = (t_sat >= last_event_reg) ? t_sat - last_event_reg : '0;
                e2 = make_event(dl, NOTE_OFF, key, held_vel_reg);
                last_next = t_sat;
            end
            expect_next = 1'b1;
        end
        // concatenate the two events
        burst.count = 4'(e1.nbytes) + 4'(e2.nbytes);
        for (int i = 0; i < 7; i++)
            burst.bytes[i] = e1.bytes[i];
        for (int i = 0; i < 7; i++)
            if (3'(i) < e2.nbytes)
                burst.bytes[4'(i) + 4'(e1.nbytes)] = e2.bytes[i];
    end

    // staging register and note state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            staccato_reg      <= '0;
            stage_reg         <= 1'b0;
            last_event_reg    <= '0;
            expect_start_reg  <= 1'b1;
            held_vel_reg      <= '0;
            held_key_reg      <= '0;
            pending_reg       <= 1'b0;
            pending_start_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                staccato_reg <= cfg_data;
            if (load)
            begin
                last_event_reg    <= last_next;
                expect_start_reg  <= expect_next;
                held_vel_reg      <= hvel_next;
                held_key_reg      <= hkey_next;
                pending_reg       <= pend_next;
                pending_start_reg <= pstart_next;
            end
            if (take)
                stage_reg <= 1'b1;
            else if (load)
                stage_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= in_data;
    end

    a_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg && busy) |-> !in_ready)
        else $error("request taken while staged item blocked");

    a_pend_stacc: assert property (@(posedge clk) disable iff (!rst_n)
        (load && pend_next && !pending_reg) |-> (staccato_reg != 16'd0))
        else $error("note-off held without staccato");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (burst.count <= 4'd14))
        else $error("burst too long");

endmodule

/* hdl/pbme_key.sv */
// frequency to key through 127 threshold compares, registered
module pbme_key
    import pbme_pkg::*;
#(
    parameter int FREQ_FRAC_BITS = 8
)
(
    input  logic        clk,
    input  logic        en,
    input  logic [23:0] freq,
    output logic [6:0]  key
);

    logic [126:0] hit;
    logic [6:0]   cnt;
    logic [6:0]   key_reg;

    // lhs = f*8e9 against 55*rom<<(oct+frac); compared as f*8 vs thr*55/1e9 scaled
    // compare f*8*1e9 >= 55*rom*2^(oct+frac): all terms constant except f
    always_comb
    begin
        for (int k = 1; k <= 127; k++)
        begin
            logic [69:0] lhs;
            logic [69:0] rhs;
            lhs = {46'd0, freq} * 70'd8000000000;
            rhs = ({38'd0, thr_rom(4'((k + 3) % 12))} * 70'd55)
                  << ((k + 3) / 12 + FREQ_FRAC_BITS);
            hit[k - 1] = (lhs >= rhs);
        end
        // thresholds rise monotonically, so the highest hit gives the key
        cnt = '0;
        for (int k = 0; k < 127; k++)
            if (hit[k])
                cnt = 7'(k + 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            key_reg <= cnt;
    end

    assign key = key_reg;

endmodule

/* hdl/pbme_out.sv */
// byte serializer for one registered burst, driving the output straight from the burst register
module pbme_out
    import pbme_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  pbme_burst_t burst,
    output logic        busy,
    output logic        out_valid,
    input  logic        out_ready,
    output pbme_out_t   out_data
);

    pbme_burst_t burst_reg;
    logic [3:0]  idx_reg;
    logic        valid_reg;

    assign busy      = valid_reg && !(out_ready && idx_reg + 4'd1 == burst_reg.count);
    assign out_valid = valid_reg;
    assign out_data.midi_byte = burst_reg.bytes[idx_reg];
    assign out_data.last_byte = (idx_reg + 4'd1 == burst_reg.count);

    // step through bytes, load a new burst when idle or finishing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            burst_reg <= burst;
            idx_reg   <= '0;
            valid_reg <= (burst.count != 4'd0);
        end
        else if (valid_reg && out_ready)
        begin
            if (out_data.last_byte)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 4'd1;
        end
    end

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (burst_reg.count != 4'd0 && idx_reg < burst_reg.count))
        else $error("byte index out of burst");

    a_last_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && out_ready && out_data.last_byte && !load) |=> !valid_reg)
        else $error("valid held after last byte");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> valid_reg)
        else $error("byte dropped while stalled");

endmodule
